/* rtl/dtse_pkg.sv */
// Shared types, codes and helpers for the DMA transfer/search engine.
// Used by dtse_front, dtse_back and dma_transfer_search_engine; no dependencies.
`timescale 1ns / 1ps

package dtse_pkg;

  // input action codes
  localparam logic [1:0] ACT_START     = 2'd0;
  localparam logic [1:0] ACT_READ_REQ  = 2'd1;
  localparam logic [1:0] ACT_READ_DATA = 2'd2;

  // bus operation codes
  localparam logic [1:0] BUS_NONE  = 2'd0;
  localparam logic [1:0] BUS_READ  = 2'd1;
  localparam logic [1:0] BUS_WRITE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_PORT_A_START = 3'd0;
  localparam logic [2:0] REG_PORT_B_START = 3'd1;
  localparam logic [2:0] REG_PORT_A_MODE  = 3'd2;
  localparam logic [2:0] REG_PORT_B_MODE  = 3'd3;
  localparam logic [2:0] REG_CONTROL      = 3'd4;
  localparam logic [2:0] REG_MATCH_BYTE   = 3'd5;
  localparam logic [2:0] REG_MASK_BYTE    = 3'd6;
  localparam logic [2:0] REG_BLOCK_LENGTH = 3'd7;

  // port mode bits
  localparam int MODE_IO    = 0;
  localparam int MODE_INC   = 1;
  localparam int MODE_FIXED = 2;

  // control bits
  localparam int CTL_TRANSFER   = 0;
  localparam int CTL_SEARCH     = 1;
  localparam int CTL_A_SRC      = 2;
  localparam int CTL_CONTINUOUS = 3;
  localparam int CTL_INT_EN     = 4;

  // queue geometry (both internal queues)
  localparam int          QPTR_W = 1;
  localparam int          QCNT_W = 2;
  localparam logic [1:0]  QDEPTH = 2'd2;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_START,
    CMD_READ_REQ,
    CMD_READ_DATA
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] port_a_start;
    logic [15:0] port_b_start;
    logic [2:0]  port_a_mode;
    logic [2:0]  port_b_mode;
    logic [4:0]  control;
    logic [7:0]  match_byte;
    logic [7:0]  mask_byte;
    logic [15:0] block_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  bus_op;
    logic [15:0] bus_address;
    logic        bus_is_io;
    logic [7:0]  write_data;
    logic        match_found;
    logic        end_of_block;
    logic        interrupt;
    logic        busy_res;
    logic        keep_bus;
  } result_t;

  // one address step: hold, up or down, wrapping at 16 bits
  function automatic logic [15:0] step_addr(input logic [15:0] addr,
                                            input logic [2:0]  mode);
    logic [15:0] res;
    if (mode[MODE_FIXED]) begin
      res = addr;
    end else if (mode[MODE_INC]) begin
      res = addr + 16'd1;
    end else begin
      res = addr - 16'd1;
    end
    return res;
  endfunction

endpackage

/* rtl/dma_transfer_search_engine.sv */
// Path: an accepted item is registered in the command queue, executes from its head
//   and its result is registered in the result queue; a full result queue stalls it.
// Throughput: one item per cycle unless stalled; each is one address step or compare.
// Both internal queues hold two entries, so in_full/out_empty decouple the sides.
// Reset (rst_n low, synchronous) clears all registers, addresses, count and queues.
`timescale 1ns / 1ps

// Top level: configuration registers plus front and back ends.
// Depends on dtse_pkg, dtse_front and dtse_back.
module dma_transfer_search_engine (
  input  logic        clk,
  input  logic        rst_n,
  // input queue
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_read_data,
  // result queue
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_bus_op,
  output logic [15:0] out_bus_address,
  output logic        out_bus_is_io,
  output logic [7:0]  out_write_data,
  output logic        out_match_found,
  output logic        out_end_of_block,
  output logic        out_interrupt,
  output logic        out_busy_res,
  output logic        out_keep_bus,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dtse_pkg::cfg_t    cfg_r;
  logic              cmd_valid;
  dtse_pkg::cmd_t    cmd;
  logic              cmd_pop;
  dtse_pkg::result_t res_head;

  assign cfg_ready = 1'b1;

  // configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dtse_pkg::REG_PORT_A_START: cfg_r.port_a_start <= cfg_data;
        dtse_pkg::REG_PORT_B_START: cfg_r.port_b_start <= cfg_data;
        dtse_pkg::REG_PORT_A_MODE:  cfg_r.port_a_mode  <= cfg_data[2:0];
        dtse_pkg::REG_PORT_B_MODE:  cfg_r.port_b_mode  <= cfg_data[2:0];
        dtse_pkg::REG_CONTROL:      cfg_r.control      <= cfg_data[4:0];
        dtse_pkg::REG_MATCH_BYTE:   cfg_r.match_byte   <= cfg_data[7:0];
        dtse_pkg::REG_MASK_BYTE:    cfg_r.mask_byte    <= cfg_data[7:0];
        dtse_pkg::REG_BLOCK_LENGTH: cfg_r.block_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dtse_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_action    (in_action),
    .in_read_data (in_read_data),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  dtse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .res_head  (res_head)
  );

  // result fields
  assign out_bus_op       = res_head.bus_op;
  assign out_bus_address  = res_head.bus_address;
  assign out_bus_is_io    = res_head.bus_is_io;
  assign out_write_data   = res_head.write_data;
  assign out_match_found  = res_head.match_found;
  assign out_end_of_block = res_head.end_of_block;
  assign out_interrupt    = res_head.interrupt;
  assign out_busy_res     = res_head.busy_res;
  assign out_keep_bus     = res_head.keep_bus;

endmodule

/* rtl/dtse_front.sv */
// Front end: accepts input items, decodes the action into a command and
// buffers it in a two-entry command queue. Depends on dtse_pkg.
`timescale 1ns / 1ps

module dtse_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic [1:0]       in_action,
  input  logic [7:0]       in_read_data,
  output logic             cmd_valid,
  output dtse_pkg::cmd_t   cmd,
  input  logic             cmd_pop
);

  dtse_pkg::cmd_t                q_mem_r [dtse_pkg::QDEPTH];
  logic [dtse_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [dtse_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [dtse_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          push_acc;
  logic                          pop_acc;
  dtse_pkg::cmd_t                dec_cmd;

  // decode the action code
  always_comb begin
    dec_cmd.data = in_read_data;
    unique case (in_action)
      dtse_pkg::ACT_START:     dec_cmd.kind = dtse_pkg::CMD_START;
      dtse_pkg::ACT_READ_REQ:  dec_cmd.kind = dtse_pkg::CMD_READ_REQ;
      dtse_pkg::ACT_READ_DATA: dec_cmd.kind = dtse_pkg::CMD_READ_DATA;
      default:                 dec_cmd.kind = dtse_pkg::CMD_NOP;
    endcase
  end

  // queue handshake
  assign in_full   = (cnt_r == dtse_pkg::QDEPTH);
  assign push_acc  = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign pop_acc   = cmd_pop && cmd_valid;
  assign cmd       = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_acc ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_acc ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_acc && !pop_acc) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_acc && !push_acc) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // command storage
  always_ff @(posedge clk) begin
    if (push_acc) begin
      q_mem_r[wr_ptr_r] <= dec_cmd;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dtse_pkg::QDEPTH)
    else $error("command queue overfilled");

  a_push_to_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) && push_acc |=> cmd_valid)
    else $error("pushed command not visible");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == dtse_pkg::QDEPTH) |-> (wr_ptr_r == rd_ptr_r))
    else $error("command queue pointers out of step");

endmodule

/* rtl/dtse_back.sv */
// Back end: executes commands against the address/count state and queues
// one result per command in a two-entry result queue. Depends on dtse_pkg.
`timescale 1ns / 1ps

module dtse_back (
  input  logic             clk,
  input  logic             rst_n,
  input  dtse_pkg::cfg_t   cfg,
  input  logic             cmd_valid,
  input  dtse_pkg::cmd_t   cmd,
  output logic             cmd_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output dtse_pkg::result_t res_head
);

  // engine state
  logic [15:0] addr_a_r, addr_a_nxt;
  logic [15:0] addr_b_r, addr_b_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;
  logic        running_r, running_nxt;
  logic        past_first_r, past_first_nxt;

  // result queue
  dtse_pkg::result_t             oq_mem_r [dtse_pkg::QDEPTH];
  logic [dtse_pkg::QPTR_W-1:0]   oq_wr_r, oq_rd_r;
  logic [dtse_pkg::QCNT_W-1:0]   oq_cnt_r, oq_cnt_nxt;
  logic                          oq_full;
  logic                          oq_pop;

  logic              exec;
  dtse_pkg::result_t res;
  logic              a_src;
  logic [15:0]       step_a;
  logic [15:0]       step_b;
  logic              hit;
  logic              end_hit;

  assign oq_full  = (oq_cnt_r == dtse_pkg::QDEPTH);
  assign exec     = cmd_valid && !oq_full;
  assign cmd_pop  = exec;
  assign oq_pop   = out_pop && !out_empty;
  assign out_empty = (oq_cnt_r == '0);
  assign res_head  = oq_mem_r[oq_rd_r];

  assign a_src   = cfg.control[dtse_pkg::CTL_A_SRC];
  assign step_a  = past_first_r ? dtse_pkg::step_addr(addr_a_r, cfg.port_a_mode) : addr_a_r;
  assign step_b  = past_first_r ? dtse_pkg::step_addr(addr_b_r, cfg.port_b_mode) : addr_b_r;
  assign hit     = cfg.control[dtse_pkg::CTL_SEARCH] &&
                   (((cmd.data ^ cfg.match_byte) & ~cfg.mask_byte) == 8'd0);
  // stop after length+1 bytes; a count that wraps to zero ends a 65536-byte block
  assign end_hit = (byte_count_r == 16'hFFFF) ||
                   ((cfg.block_length != 16'd0) && (byte_count_r >= cfg.block_length));

  // command execution
  always_comb begin
    addr_a_nxt     = addr_a_r;
    addr_b_nxt     = addr_b_r;
    byte_count_nxt = byte_count_r;
    running_nxt    = running_r;
    past_first_nxt = past_first_r;
    res            = '0;
    unique case (cmd.kind)
      dtse_pkg::CMD_START: begin
        addr_a_nxt     = cfg.port_a_start;
        addr_b_nxt     = cfg.port_b_start;
        byte_count_nxt = 16'd0;
        running_nxt    = 1'b1;
        past_first_nxt = 1'b0;
      end
      dtse_pkg::CMD_READ_REQ: begin
        if (running_r) begin
          addr_a_nxt      = step_a;
          addr_b_nxt      = step_b;
          past_first_nxt  = 1'b1;
          res.bus_op      = dtse_pkg::BUS_READ;
          res.bus_address = a_src ? step_a : step_b;
          res.bus_is_io   = a_src ? cfg.port_a_mode[dtse_pkg::MODE_IO]
                                  : cfg.port_b_mode[dtse_pkg::MODE_IO];
        end
      end
      dtse_pkg::CMD_READ_DATA: begin
        if (running_r) begin
          byte_count_nxt   = byte_count_r + 16'd1;
          res.match_found  = hit;
          res.end_of_block = end_hit;
          running_nxt      = !(hit || end_hit);
          res.interrupt    = (hit || end_hit) && cfg.control[dtse_pkg::CTL_INT_EN];
          if (cfg.control[dtse_pkg::CTL_TRANSFER]) begin
            res.bus_op      = dtse_pkg::BUS_WRITE;
            res.bus_address = a_src ? addr_b_r : addr_a_r;
            res.bus_is_io   = a_src ? cfg.port_b_mode[dtse_pkg::MODE_IO]
                                    : cfg.port_a_mode[dtse_pkg::MODE_IO];
            res.write_data  = cmd.data;
          end
        end
      end
      default: begin
      end
    endcase
    res.busy_res = running_nxt;
    res.keep_bus = running_nxt && cfg.control[dtse_pkg::CTL_CONTINUOUS];
  end

  // engine state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_a_r     <= '0;
      addr_b_r     <= '0;
      byte_count_r <= '0;
      running_r    <= 1'b0;
      past_first_r <= 1'b0;
    end else if (exec) begin
      addr_a_r     <= addr_a_nxt;
      addr_b_r     <= addr_b_nxt;
      byte_count_r <= byte_count_nxt;
      running_r    <= running_nxt;
      past_first_r <= past_first_nxt;
    end
  end

  // result queue count
  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (exec && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (oq_pop && !exec) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (exec) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (exec) begin
      oq_mem_r[oq_wr_r] <= res;
    end
  end

  a_keep_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && res_head.keep_bus |-> res_head.busy_res)
    else $error("keep_bus without busy");

  a_match_stops: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && res_head.match_found |-> !res_head.busy_res)
    else $error("match did not stop engine");

  a_intr_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && res_head.interrupt |-> (res_head.match_found || res_head.end_of_block))
    else $error("interrupt without stop cause");

  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    exec && (cmd.kind == dtse_pkg::CMD_START) |=> running_r && !past_first_r)
    else $error("start did not arm engine");

endmodule

/* sim/tb_dma_transfer_search_engine.sv */
// Testbench for dma_transfer_search_engine: directed and random requests checked
// against a cycle-free predictor of the engine. Depends on dtse_pkg and the RTL.
`timescale 1ns / 1ps

module tb_dma_transfer_search_engine;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT  = 1000000;
  localparam int         DRAIN_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_action = dtse_pkg::ACT_START;
  logic [7:0]  in_read_data = 8'h00;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_bus_op;
  logic [15:0] out_bus_address;
  logic        out_bus_is_io;
  logic [7:0]  out_write_data;
  logic        out_match_found;
  logic        out_end_of_block;
  logic        out_interrupt;
  logic        out_busy_res;
  logic        out_keep_bus;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = dtse_pkg::REG_PORT_A_START;
  logic [15:0] cfg_data = 16'h0000;

  dma_transfer_search_engine dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_action        (in_action),
    .in_read_data     (in_read_data),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_bus_op       (out_bus_op),
    .out_bus_address  (out_bus_address),
    .out_bus_is_io    (out_bus_is_io),
    .out_write_data   (out_write_data),
    .out_match_found  (out_match_found),
    .out_end_of_block (out_end_of_block),
    .out_interrupt    (out_interrupt),
    .out_busy_res     (out_busy_res),
    .out_keep_bus     (out_keep_bus),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the registers and engine state
  dtse_pkg::cfg_t dma_cfg = '0;
  logic [15:0] ptr_a = 16'h0000;
  logic [15:0] ptr_b = 16'h0000;
  logic [15:0] bytes_moved = 16'h0000;
  logic        engine_on = 1'b0;
  logic        first_done = 1'b0;

  dtse_pkg::result_t pending_results[$];

  int tx_idle_pct = 13;
  int rx_idle_pct = 71;
  int rx_hold = 0;
  int cycle_count = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int unexpected = 0;
  int config_phases = 0;

  // one address step of a port: hold, up or down, wrapping at 16 bits
  function automatic logic [15:0] advance_port(input logic [15:0] addr,
                                               input logic [2:0]  mode);
    if (mode[dtse_pkg::MODE_FIXED]) return addr;
    return mode[dtse_pkg::MODE_INC] ? addr + 16'd1 : addr + 16'hFFFF;
  endfunction

  // expected result of one accepted request; updates the engine state
  function automatic dtse_pkg::result_t dma_step(input logic [1:0] act,
                                                 input logic [7:0] rdata);
    dtse_pkg::result_t r;
    logic              a_src;
    r = '0;
    a_src = dma_cfg.control[dtse_pkg::CTL_A_SRC];
    case (act)
      dtse_pkg::ACT_START: begin
        ptr_a = dma_cfg.port_a_start;
        ptr_b = dma_cfg.port_b_start;
        bytes_moved = 16'h0000;
        engine_on = 1'b1;
        first_done = 1'b0;
      end
      dtse_pkg::ACT_READ_REQ: begin
        if (engine_on) begin
          // no step before the first byte of a block
          if (first_done) begin
            ptr_a = advance_port(ptr_a, dma_cfg.port_a_mode);
            ptr_b = advance_port(ptr_b, dma_cfg.port_b_mode);
          end else begin
            first_done = 1'b1;
          end
          r.bus_op = dtse_pkg::BUS_READ;
          r.bus_address = a_src ? ptr_a : ptr_b;
          r.bus_is_io = a_src ? dma_cfg.port_a_mode[dtse_pkg::MODE_IO]
                              : dma_cfg.port_b_mode[dtse_pkg::MODE_IO];
        end
      end
      dtse_pkg::ACT_READ_DATA: begin
        if (engine_on) begin
          // masked compare: set mask bits are don't-care
          if (dma_cfg.control[dtse_pkg::CTL_SEARCH] &&
              ((rdata ^ dma_cfg.match_byte) & ~dma_cfg.mask_byte) == 8'h00) begin
            engine_on = 1'b0;
            r.match_found = 1'b1;
          end
          if (dma_cfg.control[dtse_pkg::CTL_TRANSFER]) begin
            r.bus_op = dtse_pkg::BUS_WRITE;
            r.bus_address = a_src ? ptr_b : ptr_a;
            r.bus_is_io = a_src ? dma_cfg.port_b_mode[dtse_pkg::MODE_IO]
                                : dma_cfg.port_a_mode[dtse_pkg::MODE_IO];
            r.write_data = rdata;
          end
          // length 0 runs the full 64K bytes until the count wraps
          bytes_moved = bytes_moved + 16'd1;
          if (bytes_moved == 16'd0 ||
              (dma_cfg.block_length != 16'd0 &&
               bytes_moved - 16'd1 >= dma_cfg.block_length)) begin
            engine_on = 1'b0;
            r.end_of_block = 1'b1;
          end
          r.interrupt = !engine_on && dma_cfg.control[dtse_pkg::CTL_INT_EN];
        end
      end
      default: ;
    endcase
    r.busy_res = engine_on;
    r.keep_bus = engine_on && dma_cfg.control[dtse_pkg::CTL_CONTINUOUS];
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
    if (act_val !== exp_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
    end
  endtask

  task automatic check_result();
    dtse_pkg::result_t exp_r;
    if (pending_results.size() == 0) begin
      unexpected++;
      $display("%0t: result with none expected, actual bus_op %h address %h",
               $time, out_bus_op, out_bus_address);
    end else begin
      exp_r = pending_results.pop_front();
      results_checked++;
      compare_field("bus_op", 16'(exp_r.bus_op), 16'(out_bus_op));
      compare_field("bus_address", exp_r.bus_address, out_bus_address);
      compare_field("bus_is_io", 16'(exp_r.bus_is_io), 16'(out_bus_is_io));
      compare_field("write_data", 16'(exp_r.write_data), 16'(out_write_data));
      compare_field("match_found", 16'(exp_r.match_found), 16'(out_match_found));
      compare_field("end_of_block", 16'(exp_r.end_of_block), 16'(out_end_of_block));
      compare_field("interrupt", 16'(exp_r.interrupt), 16'(out_interrupt));
      compare_field("busy_res", 16'(exp_r.busy_res), 16'(out_busy_res));
      compare_field("keep_bus", 16'(exp_r.keep_bus), 16'(out_keep_bus));
    end
  endtask

  // scoreboard: results checked, register writes and requests tracked at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) check_result();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dtse_pkg::REG_PORT_A_START: dma_cfg.port_a_start = cfg_data;
          dtse_pkg::REG_PORT_B_START: dma_cfg.port_b_start = cfg_data;
          dtse_pkg::REG_PORT_A_MODE:  dma_cfg.port_a_mode = cfg_data[2:0];
          dtse_pkg::REG_PORT_B_MODE:  dma_cfg.port_b_mode = cfg_data[2:0];
          dtse_pkg::REG_CONTROL:      dma_cfg.control = cfg_data[4:0];
          dtse_pkg::REG_MATCH_BYTE:   dma_cfg.match_byte = cfg_data[7:0];
          dtse_pkg::REG_MASK_BYTE:    dma_cfg.mask_byte = cfg_data[7:0];
          dtse_pkg::REG_BLOCK_LENGTH: dma_cfg.block_length = cfg_data;
          default: ;
        endcase
      end
      if (in_push && !in_full) pending_results.push_back(dma_step(in_action, in_read_data));
    end
  end

  // result side: random pops, or a long hold when requested
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // send one request; push stays high afterwards for back-to-back requests
  task automatic send_request(input logic [1:0] act, input logic [7:0] data);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_action <= act;
    in_read_data <= data;
    @(posedge clk);
    while (in_full) @(posedge clk);
    requests_sent++;
  endtask

  // stop sending and wait until every expected result has been popped
  task automatic drain(input int extra);
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // narrow registers get random junk in the unused upper bits
  task automatic load_config(input logic [15:0] a_start, input logic [15:0] b_start,
                             input logic [2:0] a_mode, input logic [2:0] b_mode,
                             input logic [4:0] ctl, input logic [7:0] match,
                             input logic [7:0] mask, input logic [15:0] blen);
    logic [31:0] junk;
    drain(DRAIN_CYCLES);
    junk = $urandom;
    write_reg(dtse_pkg::REG_PORT_A_START, a_start);
    write_reg(dtse_pkg::REG_PORT_B_START, b_start);
    write_reg(dtse_pkg::REG_PORT_A_MODE, {junk[12:0], a_mode});
    write_reg(dtse_pkg::REG_PORT_B_MODE, {junk[25:13], b_mode});
    write_reg(dtse_pkg::REG_CONTROL, {junk[10:0], ctl});
    write_reg(dtse_pkg::REG_MATCH_BYTE, {junk[31:24], match});
    write_reg(dtse_pkg::REG_MASK_BYTE, {junk[23:16], mask});
    write_reg(dtse_pkg::REG_BLOCK_LENGTH, blen);
    cfg_valid <= 1'b0;
    config_phases++;
  endtask

  // returned byte: now and then forced to hit the masked match
  function automatic logic [7:0] pick_data();
    logic [7:0] r;
    r = 8'($urandom_range(0, 255));
    if (dma_cfg.control[dtse_pkg::CTL_SEARCH] && $urandom_range(7) == 0)
      r = (dma_cfg.match_byte & ~dma_cfg.mask_byte) | (r & dma_cfg.mask_byte);
    return r;
  endfunction

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // one block: start, then mostly request/data pairs with some noise
  task automatic run_block();
    int n;
    int r;
    send_request(dtse_pkg::ACT_START, 8'($urandom_range(0, 255)));
    if (dma_cfg.block_length != 16'd0 && dma_cfg.block_length < 16'd20)
      n = dma_cfg.block_length + 1 + $urandom_range(0, 2);
    else
      n = $urandom_range(1, 24);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 80) begin
        send_request(dtse_pkg::ACT_READ_REQ, 8'($urandom_range(0, 255)));
        send_request(dtse_pkg::ACT_READ_DATA, pick_data());
      end else if (r < 87) begin
        send_request(dtse_pkg::ACT_READ_REQ, 8'($urandom_range(0, 255)));
      end else if (r < 93) begin
        send_request(dtse_pkg::ACT_READ_DATA, pick_data());
      end else if (r < 97) begin
        send_request(ACT_UNUSED, 8'($urandom_range(0, 255)));
      end else begin
        send_request(dtse_pkg::ACT_START, 8'($urandom_range(0, 255)));
      end
    end
    // requests after the block has likely stopped
    if ($urandom_range(3) == 0)
      send_request($urandom_range(0, 1) ? dtse_pkg::ACT_READ_REQ : dtse_pkg::ACT_READ_DATA,
                   pick_data());
  endtask

  task automatic test_directed();
    // wrap of both ports, I/O destination, masked match together with end of block
    load_config(16'hFFFF, 16'h0000, 3'b010, 3'b001, 5'b11111, 8'h5A, 8'h0F, 16'd2);
    send_request(dtse_pkg::ACT_READ_REQ, 8'hFF);
    send_request(dtse_pkg::ACT_READ_DATA, 8'hA5);
    send_request(ACT_UNUSED, 8'h00);
    send_request(dtse_pkg::ACT_START, 8'h00);
    send_request(dtse_pkg::ACT_READ_REQ, 8'h00);
    send_request(dtse_pkg::ACT_READ_DATA, 8'h00);
    send_request(dtse_pkg::ACT_READ_REQ, 8'h00);
    send_request(dtse_pkg::ACT_READ_REQ, 8'hFF);
    send_request(dtse_pkg::ACT_READ_DATA, 8'hFF);
    send_request(ACT_UNUSED, 8'hFF);
    send_request(dtse_pkg::ACT_READ_REQ, 8'h00);
    send_request(dtse_pkg::ACT_READ_DATA, 8'h53);
    send_request(dtse_pkg::ACT_READ_DATA, 8'h53);
    // fixed addresses, B source, no transfer or search
    load_config(16'h8000, 16'h7FFF, 3'b100, 3'b111, 5'b00000, 8'hFF, 8'hFF, 16'd0);
    send_request(dtse_pkg::ACT_START, 8'hFF);
    send_request(dtse_pkg::ACT_READ_REQ, 8'h00);
    send_request(dtse_pkg::ACT_READ_DATA, 8'h3C);
    send_request(dtse_pkg::ACT_READ_REQ, 8'h00);
    send_request(dtse_pkg::ACT_READ_REQ, 8'h00);
    send_request(dtse_pkg::ACT_READ_DATA, 8'hC3);
    // full mask always matches; longest non-wrapping length
    load_config(16'h1234, 16'hFFFF, 3'b000, 3'b110, 5'b01011, 8'h00, 8'hFF, 16'd65535);
    send_request(dtse_pkg::ACT_START, 8'h00);
    send_request(dtse_pkg::ACT_READ_REQ, 8'h00);
    send_request(dtse_pkg::ACT_READ_DATA, 8'h81);
    send_request(dtse_pkg::ACT_READ_REQ, 8'h00);
  endtask

  task automatic test_random(input int n_requests);
    int          stop_at;
    int          phase_end;
    logic [7:0]  mask;
    logic [15:0] blen;
    stop_at = requests_sent + n_requests;
    while (requests_sent < stop_at) begin
      case ($urandom_range(2))
        0: mask = 8'h00;
        1: mask = 8'hFF;
        default: mask = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(9))
        0: blen = 16'd0;
        1: blen = 16'd65535;
        default: blen = 16'($urandom_range(1, 12));
      endcase
      load_config(pick_addr(), pick_addr(), 3'($urandom_range(0, 7)),
                  3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                  8'($urandom_range(0, 255)), mask, blen);
      phase_end = requests_sent + n_requests / 5;
      while (requests_sent < phase_end && requests_sent < stop_at) run_block();
    end
  endtask

  // long result stall while requests keep coming, so the input fills up
  task automatic test_input_stall();
    int saved_tx;
    saved_tx = tx_idle_pct;
    tx_idle_pct = 0;
    load_config(16'h4000, 16'hC000, 3'b010, 3'b011, 5'b11101, 8'hEE, 8'h00, 16'd40);
    rx_hold = 400;
    send_request(dtse_pkg::ACT_START, 8'h00);
    for (int i = 0; i < 30; i++) begin
      send_request(dtse_pkg::ACT_READ_REQ, 8'h00);
      send_request(dtse_pkg::ACT_READ_DATA, 8'($urandom_range(0, 255)));
    end
    tx_idle_pct = saved_tx;
  endtask

  // length 0 means a 65536-byte block, so a long run of bytes never ends it
  task automatic test_zero_length_block();
    load_config(16'h0100, 16'hFF00, 3'b010, 3'b000, 5'b10101, 8'h00, 8'h00, 16'd0);
    send_request(dtse_pkg::ACT_START, 8'h00);
    send_request(dtse_pkg::ACT_READ_REQ, 8'h00);
    for (int i = 0; i < 40; i++) send_request(dtse_pkg::ACT_READ_DATA, 8'($urandom_range(0, 255)));
    send_request(dtse_pkg::ACT_READ_REQ, 8'h00);
    send_request(dtse_pkg::ACT_READ_DATA, 8'hFF);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(590);
    test_input_stall();
    tx_idle_pct = 71;
    rx_idle_pct = 13;
    test_random(590);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(590);
    test_zero_length_block();
    drain(10);
    $display("Sent %0d requests over %0d register settings; checked %0d results.",
             requests_sent, config_phases, results_checked);
    $display("Covered idle/stall mixes, a long output stall and a length-0 block run.");
    if (mismatches == 0 && unexpected == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
